FILE: sv/pcds_pkg.sv
// Shared types, constants and commands for the pivot Chebyshev distance sum block.
`timescale 1ns / 1ps
`default_nettype none
package pcds_pkg;
    localparam int POINTS_MAX_DEF = 512;
    localparam int AXES_MAX_DEF   = 8;
    localparam int PIVOTS_MAX_DEF = 3;
    localparam int CFG_W          = 10;
    localparam int DIST_W         = 35;
    localparam int SQRT_BITS      = 35;
    localparam int SQ_W           = 72;
    localparam int SUM_W          = 64;
    localparam int OUT_W          = 62;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PIVOT   = 2'd1;
    localparam logic [1:0] CMD_RUN     = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_POINTS = 2'd0;
    localparam logic [1:0] REG_AXES   = 2'd1;
    localparam logic [1:0] REG_PIVOTS = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic start;       // clear run counters
        logic map_step;    // advance mapping walk by one step
        logic pair_step;   // advance pair walk by one step
        logic finish;      // latch result
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic map_done;
        logic pair_done;
    } t_dp_sts;
endpackage
`default_nettype wire

FILE: sv/pcds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pcds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/pcds_datapath.sv
// Datapath: coordinate store, mapping (squares, bitwise square root), pair walk and sum.
`timescale 1ns / 1ps
`default_nettype none
module pcds_datapath #(
    parameter int POINTS_MAX = pcds_pkg::POINTS_MAX_DEF,
    parameter int AXES_MAX   = pcds_pkg::AXES_MAX_DEF,
    parameter int PIVOTS_MAX = pcds_pkg::PIVOTS_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pcds_pkg::t_dp_cmd              i_cmd,
    output pcds_pkg::t_dp_sts                   o_sts,
    input  wire logic                           i_load_we,
    input  wire logic [8:0]                     i_point_index,
    input  wire logic [2:0]                     i_axis_index,
    input  wire logic [31:0]                    i_coord_value,
    input  wire logic                           i_pivot_we,
    input  wire logic [1:0]                     i_pivot_slot,
    input  wire logic [pcds_pkg::CFG_W-1:0]     i_point_count,
    input  wire logic [pcds_pkg::CFG_W-1:0]     i_axis_count,
    input  wire logic [pcds_pkg::CFG_W-1:0]     i_pivot_count,
    output logic [pcds_pkg::OUT_W-1:0]          o_distance_sum,
    output logic                                o_saturated
);
    localparam int PW  = $clog2(POINTS_MAX);
    localparam int AW  = (AXES_MAX > 1) ? $clog2(AXES_MAX) : 1;
    localparam int KW  = (PIVOTS_MAX > 1) ? $clog2(PIVOTS_MAX) : 1;
    localparam int CW  = $clog2(POINTS_MAX * AXES_MAX);
    localparam int MW  = $clog2(POINTS_MAX * PIVOTS_MAX);
    localparam int PCW = $clog2(POINTS_MAX + 1);
    localparam int ACW = $clog2(AXES_MAX + 1);
    localparam int KCW = $clog2(PIVOTS_MAX + 1);
    localparam int DW  = pcds_pkg::DIST_W;
    localparam int SW  = pcds_pkg::SQ_W;
    localparam int SBW = $clog2(pcds_pkg::SQRT_BITS);
    localparam int TW  = pcds_pkg::SUM_W;

    localparam logic [pcds_pkg::CFG_W-1:0] CFG_POINTS = pcds_pkg::CFG_W'(POINTS_MAX);
    localparam logic [pcds_pkg::CFG_W-1:0] CFG_AXES   = pcds_pkg::CFG_W'(AXES_MAX);
    localparam logic [pcds_pkg::CFG_W-1:0] CFG_PIVOTS = pcds_pkg::CFG_W'(PIVOTS_MAX);

    // highest power of four the root walk starts from
    localparam logic [SW-1:0] ONE_TOP = SW'(1) << (2 * (pcds_pkg::SQRT_BITS - 1));

    // clamped run sizes
    logic [PCW-1:0] r_n;
    logic [ACW-1:0] r_dims;
    logic [KCW-1:0] r_k;

    logic [PW-1:0] r_piv [PIVOTS_MAX];

    // coordinate store
    logic          cs_we;
    logic [CW-1:0] cs_waddr, cs_raddr;
    logic [31:0]   cs_rdata;

    assign cs_we = i_load_we && ({23'd0, i_point_index} < 32'(POINTS_MAX))
                   && ({29'd0, i_axis_index} < 32'(AXES_MAX));
    assign cs_waddr = CW'(32'(i_point_index) * AXES_MAX + 32'(i_axis_index));

    pcds_ram #(.WIDTH(32), .DEPTH(POINTS_MAX * AXES_MAX)) u_coord (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(i_coord_value),
        .i_raddr(cs_raddr), .o_rdata(cs_rdata)
    );

    // mapped distances
    logic          md_we;
    logic [MW-1:0] md_waddr, md_raddr;
    logic [DW-1:0] md_wdata, md_rdata;

    pcds_ram #(.WIDTH(DW), .DEPTH(POINTS_MAX * PIVOTS_MAX)) u_map (
        .i_clk(i_clk), .i_we(md_we), .i_waddr(md_waddr), .i_wdata(md_wdata),
        .i_raddr(md_raddr), .o_rdata(md_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIVOTS_MAX; s++) r_piv[s] <= '0;
        end else if (i_pivot_we && ({30'd0, i_pivot_slot} < 32'(PIVOTS_MAX))
                     && ({23'd0, i_point_index} < 32'(POINTS_MAX))) begin
            r_piv[KW'(i_pivot_slot)] <= PW'(i_point_index);
        end
    end

    // ---------------- mapping walk ----------------
    // phases per (point, pivot): read pivot coord, read point coord per axis,
    // then square-root iterations.
    typedef enum logic [5:0] {
        M_RDP  = 6'b000001,
        M_RDQ  = 6'b000010,
        M_SUB  = 6'b000100,
        M_ACC  = 6'b001000,
        M_SQRT = 6'b010000,
        M_DONE = 6'b100000
    } t_mph;
    t_mph r_mph;
    logic [PCW-1:0] r_mi;
    logic [KCW-1:0] r_mp;
    logic [ACW-1:0] r_ma;
    logic signed [31:0] r_pcoord;
    logic [32:0]        r_mag;
    logic [SW-1:0]      r_acc;
    logic [SW-1:0]      r_res;
    logic [SW-1:0]      r_one;
    logic [SBW-1:0]     r_bit;
    logic [SW-1:0]      sq_try;
    logic [SW-1:0]      sq_rem;
    logic [SW-1:0]      root_next;
    logic               sq_take;
    logic [PW-1:0]      cur_piv;

    assign cur_piv   = r_piv[KW'(r_mp)];
    assign sq_try    = r_res + r_one;
    assign sq_take   = (r_acc >= sq_try);
    assign sq_rem    = r_acc - sq_try;
    assign root_next = sq_take ? (r_res >> 1) + r_one : (r_res >> 1);

    // ---------------- pair walk ----------------
    typedef enum logic [4:0] {
        P_RDX  = 5'b00001,
        P_RDY  = 5'b00010,
        P_CMP  = 5'b00100,
        P_ADD  = 5'b01000,
        P_DONE = 5'b10000
    } t_pph;
    t_pph r_pph;
    logic [PCW-1:0] r_pi, r_pj;
    logic [KCW-1:0] r_pp;
    logic [DW-1:0]  r_x, r_best;
    logic [TW-1:0]  r_sum;

    always_comb begin
        cs_raddr = '0;
        md_raddr = '0;
        md_we    = 1'b0;
        md_waddr = MW'(32'(r_mi) * PIVOTS_MAX + 32'(r_mp));
        md_wdata = root_next[DW-1:0];
        if (r_mph == M_RDP) cs_raddr = CW'(32'(cur_piv) * AXES_MAX + 32'(r_ma));
        if (r_mph == M_RDQ) cs_raddr = CW'(32'(r_mi) * AXES_MAX + 32'(r_ma));
        if (r_mph == M_SQRT && r_bit == '0) md_we = i_cmd.map_step;
        if (r_pph == P_RDX) md_raddr = MW'(32'(r_pi) * PIVOTS_MAX + 32'(r_pp));
        if (r_pph == P_RDY) md_raddr = MW'(32'(r_pj) * PIVOTS_MAX + 32'(r_pp));
    end

    assign o_sts.map_done  = (r_mph == M_DONE);
    assign o_sts.pair_done = (r_pph == P_DONE);

    logic [DW-1:0] diff;
    assign diff = (r_x > md_rdata) ? r_x - md_rdata : md_rdata - r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mph <= M_DONE;
            r_pph <= P_DONE;
            r_n <= '0; r_dims <= '0; r_k <= '0;
            r_sum <= '0;
        end else if (i_cmd.start) begin
            r_n    <= (i_point_count > CFG_POINTS) ? PCW'(POINTS_MAX) : PCW'(i_point_count);
            r_dims <= (i_axis_count > CFG_AXES) ? ACW'(AXES_MAX) : ACW'(i_axis_count);
            r_k    <= (i_pivot_count > CFG_PIVOTS) ? KCW'(PIVOTS_MAX) : KCW'(i_pivot_count);
            r_mi <= '0; r_mp <= '0; r_ma <= '0;
            r_acc <= '0; r_res <= '0; r_one <= ONE_TOP;
            r_bit <= SBW'(pcds_pkg::SQRT_BITS - 1);
            r_mph <= M_RDP;
            r_pi <= '0; r_pj <= PCW'(1); r_pp <= '0; r_best <= '0;
            r_sum <= '0;
            r_pph <= P_RDX;
        end else begin
            if (i_cmd.map_step) begin
                case (r_mph)
                    M_RDP: begin
                        if (r_mi >= r_n) begin
                            r_mph <= M_DONE;
                        end else if (r_mp >= r_k) begin
                            r_mp <= '0;
                            r_mi <= r_mi + 1'b1;
                        end else if (r_ma >= r_dims) begin
                            r_mph <= M_SQRT;
                        end else begin
                            r_mph <= M_RDQ;
                        end
                    end
                    M_RDQ: begin
                        r_pcoord <= cs_rdata;
                        r_mph <= M_SUB;
                    end
                    M_SUB: begin
                        r_mag <= ($signed({r_pcoord[31], r_pcoord}) >=
                                  $signed({cs_rdata[31], cs_rdata}))
                            ? 33'({r_pcoord[31], r_pcoord}) - 33'({cs_rdata[31], cs_rdata})
                            : 33'({cs_rdata[31], cs_rdata}) - 33'({r_pcoord[31], r_pcoord});
                        r_mph <= M_ACC;
                    end
                    M_ACC: begin
                        r_acc <= r_acc + SW'(66'(r_mag) * 66'(r_mag));
                        r_ma  <= r_ma + 1'b1;
                        r_mph <= M_RDP;
                    end
                    M_SQRT: begin
                        // one root bit per cycle: compare and subtract against the remainder
                        if (r_bit == '0) begin
                            r_bit <= SBW'(pcds_pkg::SQRT_BITS - 1);
                            r_acc <= '0;
                            r_res <= '0;
                            r_one <= ONE_TOP;
                            r_ma  <= '0;
                            r_mp  <= r_mp + 1'b1;
                            r_mph <= M_RDP;
                        end else begin
                            if (sq_take) r_acc <= sq_rem;
                            r_res <= root_next;
                            r_one <= r_one >> 2;
                            r_bit <= r_bit - 1'b1;
                        end
                    end
                    default: r_mph <= M_DONE;
                endcase
            end
            if (i_cmd.pair_step) begin
                case (r_pph)
                    P_RDX: begin
                        if (r_pj >= r_n) begin
                            if (32'(r_pi) + 2 >= 32'(r_n)) begin
                                r_pph <= P_DONE;
                            end else begin
                                r_pi <= r_pi + 1'b1;
                                r_pj <= r_pi + PCW'(2);
                            end
                        end else if (r_pp >= r_k) begin
                            r_pph <= P_ADD;
                        end else begin
                            r_pph <= P_RDY;
                        end
                    end
                    P_RDY: begin
                        r_x <= md_rdata;
                        r_pph <= P_CMP;
                    end
                    P_CMP: begin
                        if (diff > r_best) r_best <= diff;
                        r_pp <= r_pp + 1'b1;
                        r_pph <= P_RDX;
                    end
                    P_ADD: begin
                        r_sum  <= r_sum + TW'(r_best);
                        r_best <= '0;
                        r_pp   <= '0;
                        r_pj   <= r_pj + 1'b1;
                        r_pph  <= P_RDX;
                    end
                    default: r_pph <= P_DONE;
                endcase
            end
        end
    end

    // sum stays far below 2^64 for in-range sizes, so only the output clips
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_sum[TW-1:pcds_pkg::OUT_W-1] != '0) begin
                o_distance_sum <= '1;
                o_saturated    <= 1'b1;
            end else begin
                o_distance_sum <= {r_sum[pcds_pkg::OUT_W-2:0], 1'b0};
                o_saturated    <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/pcds_ctrl.sv
// Controller: command decode, run sequencing and output handshake.
`timescale 1ns / 1ps
`default_nettype none
module pcds_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_command,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_load_we,
    output logic                   o_pivot_we,
    output pcds_pkg::t_dp_cmd      o_cmd,
    input  wire pcds_pkg::t_dp_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAP  = 4'b0010,
        S_PAIR = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;
    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_load_we  = acc && (i_command == pcds_pkg::CMD_LOAD);
    assign o_pivot_we = acc && (i_command == pcds_pkg::CMD_PIVOT);

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc && i_command == pcds_pkg::CMD_RUN) begin
                    o_cmd.start = 1'b1;
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map_step = 1'b1;
                if (i_sts.map_done) n_state = S_PAIR;
            end
            S_PAIR: begin
                o_cmd.pair_step = 1'b1;
                if (i_sts.pair_done) n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free or being emptied
                if (!r_valid || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule
`default_nettype wire

FILE: sv/pivot_chebyshev_distance_sum.sv
// Top level of the pivot-space Chebyshev distance sum block.
// A run transaction holds off input while a sequencer maps each point against
// each pivot (per axis, reads through the one coordinate RAM read port, then a
// setup step and a shift-and-subtract square root), and then walks every point
// pair through the mapped-distance RAM, pivot by pivot, with a summing step per
// pair. The result stays in its output register until taken. Input is accepted
// while a result waits; a later run holds in its last step until the output
// register is free.
`timescale 1ns / 1ps
`default_nettype none
module pivot_chebyshev_distance_sum #(
    parameter int POINTS_MAX = pcds_pkg::POINTS_MAX_DEF,
    parameter int AXES_MAX   = pcds_pkg::AXES_MAX_DEF,
    parameter int PIVOTS_MAX = pcds_pkg::PIVOTS_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [8:0]  i_point_index,
    input  wire logic [2:0]  i_axis_index,
    input  wire logic [31:0] i_coord_value,
    input  wire logic [1:0]  i_pivot_slot,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [61:0]      o_distance_sum,
    output logic             o_saturated,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);
    logic [9:0] r_point_count, r_axis_count, r_pivot_count;
    logic load_we, pivot_we;
    pcds_pkg::t_dp_cmd cmd;
    pcds_pkg::t_dp_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 10'd2;
            r_axis_count  <= 10'd2;
            r_pivot_count <= 10'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcds_pkg::REG_POINTS: r_point_count <= i_cfg_data;
                pcds_pkg::REG_AXES:   r_axis_count  <= {6'd0, i_cfg_data[3:0]};
                pcds_pkg::REG_PIVOTS: r_pivot_count <= {8'd0, i_cfg_data[1:0]};
                default: ;
            endcase
        end
    end

    pcds_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .o_valid(o_valid), .i_ready(i_ready),
        .o_load_we(load_we), .o_pivot_we(pivot_we), .o_cmd(cmd), .i_sts(sts)
    );

    pcds_datapath #(.POINTS_MAX(POINTS_MAX), .AXES_MAX(AXES_MAX),
                    .PIVOTS_MAX(PIVOTS_MAX)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_load_we(load_we), .i_point_index(i_point_index),
        .i_axis_index(i_axis_index), .i_coord_value(i_coord_value),
        .i_pivot_we(pivot_we), .i_pivot_slot(i_pivot_slot),
        .i_point_count(r_point_count), .i_axis_count(r_axis_count),
        .i_pivot_count(r_pivot_count),
        .o_distance_sum(o_distance_sum), .o_saturated(o_saturated)
    );
endmodule
`default_nettype wire

FILE: sv/pcds_checker.sv
// Port-level checker for the distance sum block, bound to the top level.
`timescale 1ns / 1ps
module pcds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [61:0] o_distance_sum,
    input logic        o_saturated
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance_sum))
        else $error("result dropped or changed while stalled");
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_distance_sum == 62'h3FFFFFFFFFFFFFFF)
        else $error("saturated result not at maximum");
    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_saturated |-> !o_distance_sum[0])
        else $error("unsaturated result not doubled");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule

bind pivot_chebyshev_distance_sum pcds_checker u_pcds_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_distance_sum(o_distance_sum), .o_saturated(o_saturated)
);
